>>> src/dab_pkg.sv
// Shared types, constants and field layout for the debounced alarm bank.
// Used by every module of the block; depends on nothing.
package dab_pkg;

    localparam int ALARM_COUNT = 8;
    localparam int MAX_ALARMS  = 8;
    localparam int IDX_W       = 3;
    localparam int RUN_W       = 8;
    localparam int TAG_W       = 32;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 4;
    localparam int LVL_W       = 2;
    localparam int PER_W       = 16;
    localparam int DIVISOR_W   = CNT_W + PER_W;
    localparam int DIV_STEPS   = TIME_W / 2;
    localparam int STEP_W      = 4;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CLEAR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVELS  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD  = 2'd3;

    localparam logic [63:0]      TRIGGER_RESET = 64'h0101_0101_0101_0101;
    localparam logic [63:0]      CLEAR_RESET   = 64'h0101_0101_0101_0101;
    localparam logic [15:0]      LEVELS_RESET  = 16'h0000;
    localparam logic [PER_W-1:0] PERIOD_RESET  = 16'd2000;

    // Item kinds carried on tuser
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Stream widths
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 24;

    // Per-alarm debounce record kept in the state memory
    typedef struct packed {
        logic [RUN_W-1:0] bad_run;
        logic [RUN_W-1:0] good_run;
        logic [TAG_W-1:0] last_bad_tag;
        logic [TAG_W-1:0] last_good_tag;
    } entry_t;

    // Request from the sequencer to the display divider
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic [PER_W-1:0] period;
    } div_req_t;

    // Reply from the display divider
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] pick;
    } div_rsp_t;

endpackage

>>> src/dab_state_ram.sv
// Synchronous state memory holding one debounce record per alarm.
// One write and one read port, read data registered; uses dab_pkg.
module dab_state_ram import dab_pkg::*; (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [ALARM_COUNT];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/dab_update.sv
// Debounce update for one alarm: advances the run counters and decides
// the new on/off state. Combinational; uses dab_pkg.
module dab_update import dab_pkg::*; (
    input  entry_t           cur,
    input  logic             cur_active,
    input  logic             bad,
    input  logic [TAG_W-1:0] tag,
    input  logic [RUN_W-1:0] trigger_count,
    input  logic [RUN_W-1:0] clear_count,
    output entry_t           nxt,
    output logic             nxt_active
);

    logic [RUN_W-1:0] bad_run_new;
    logic [RUN_W-1:0] good_run_new;

    // Grow the run of the reported polarity on a fresh tag, saturating
    always_comb begin
        bad_run_new  = cur.bad_run;
        good_run_new = cur.good_run;
        if (tag != cur.last_bad_tag && cur.bad_run != RUN_MAX) begin
            bad_run_new = cur.bad_run + 1'b1;
        end
        if (tag != cur.last_good_tag && cur.good_run != RUN_MAX) begin
            good_run_new = cur.good_run + 1'b1;
        end
    end

    // Apply to the record and decide the alarm state
    always_comb begin
        nxt        = cur;
        nxt_active = cur_active;
        if (bad) begin
            nxt.bad_run      = bad_run_new;
            nxt.last_bad_tag = tag;
            nxt.good_run     = '0;
            if (!cur_active) begin
                nxt_active = (bad_run_new >= trigger_count);
            end
        end else begin
            nxt.good_run      = good_run_new;
            nxt.last_good_tag = tag;
            nxt.bad_run       = '0;
            if (cur_active) begin
                nxt_active = (good_run_new < clear_count);
            end
        end
    end

endmodule

>>> src/dab_divider.sv
// Serial display-rotation divider: time mod (count * period), two bits a
// cycle, then repeated subtraction of the period. Uses dab_pkg.
module dab_divider import dab_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req,
    input  logic [TIME_W-1:0] now,
    output div_rsp_t          rsp
);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_DIV  = 2'd1;
    localparam logic [1:0] DV_PICK = 2'd2;

    logic [1:0]           state_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [PER_W-1:0]     period_reg;
    logic [TIME_W-1:0]    dividend_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [IDX_W-1:0]     pick_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   trial1;
    logic [DIVISOR_W:0]   trial2;
    logic [DIVISOR_W-1:0] rem_mid;

    // Two restoring steps per cycle
    always_comb begin
        trial1 = {rem_reg, dividend_reg[TIME_W-1]};
        if (trial1 >= {1'b0, divisor_reg}) begin
            rem_mid = DIVISOR_W'(trial1 - {1'b0, divisor_reg});
        end else begin
            rem_mid = trial1[DIVISOR_W-1:0];
        end
        trial2 = {rem_mid, dividend_reg[TIME_W-2]};
        if (trial2 >= {1'b0, divisor_reg}) begin
            rem_next = DIVISOR_W'(trial2 - {1'b0, divisor_reg});
        end else begin
            rem_next = trial2[DIVISOR_W-1:0];
        end
    end

    // Sequence the divide and the pick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DV_IDLE: begin
                    if (req.start) begin
                        state_reg <= DV_DIV;
                    end
                end
                DV_DIV: begin
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        state_reg <= DV_PICK;
                    end
                end
                DV_PICK: begin
                    if (rem_reg < {{CNT_W{1'b0}}, period_reg}) begin
                        done_reg  <= 1'b1;
                        state_reg <= DV_IDLE;
                    end
                end
                default: begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            DV_IDLE: begin
                if (req.start) begin
                    divisor_reg  <= req.count * req.period;
                    period_reg   <= req.period;
                    dividend_reg <= now;
                    rem_reg      <= '0;
                    step_reg     <= '0;
                    pick_reg     <= '0;
                end
            end
            DV_DIV: begin
                rem_reg      <= rem_next;
                dividend_reg <= dividend_reg << 2;
                step_reg     <= step_reg + 1'b1;
            end
            DV_PICK: begin
                if (rem_reg >= {{CNT_W{1'b0}}, period_reg}) begin
                    rem_reg  <= rem_reg - {{CNT_W{1'b0}}, period_reg};
                    pick_reg <= pick_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.pick = pick_reg;

endmodule

>>> src/debounced_alarm_bank.sv
// Top level of the debounced alarm bank: stream ports, configuration
// registers and item sequencer. Uses dab_pkg, dab_state_ram, dab_update, dab_divider.

// The block handles one item at a time. An item (condition report or
// clear-all) is taken when s_tready is high, which is whenever no item is
// in work. Its single result beat follows these steps in order: read the
// alarm's record from the state memory, update and write it back,
// summarize the on alarms, take the two-bit-per-cycle modulo of time_ms
// by (on count * period), subtract the period repeatedly to pick the
// shown alarm, and load the output register. With no alarm on, the
// divider is skipped. The output register holds a finished result while
// the next item is accepted. Configuration must be written by the user
// through cfg_wr_en/cfg_addr/cfg_wdata while the block is idle; the block
// does not enforce this. A display period of zero acts as one.
module debounced_alarm_bank import dab_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // alarm_index[2:0], bad[3], seq_tag[35:4], time_ms[67:36], zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic [0:0]            s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // on_mask[7:0], on_count[11:8], top_level[13:12], shown_alarm[16:14],
    // shown_valid[17], zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]              state_reg;

    // Configuration registers
    logic [63:0]             trigger_reg;
    logic [63:0]             clear_reg;
    logic [15:0]             levels_reg;
    logic [PER_W-1:0]        period_reg;

    // Latched item
    logic                    kind_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    bad_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [TIME_W-1:0]       time_reg;

    // Alarm state kept in flops
    logic [MAX_ALARMS-1:0]   active_reg;
    logic [MAX_ALARMS-1:0]   valid_reg;

    // Summary
    logic [MAX_ALARMS-1:0]   mask_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [LVL_W-1:0]        top_reg;
    logic [IDX_W-1:0]        pick_reg;

    // Output register
    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     m_tdata_reg;

    logic                    s_beat;
    logic                    idx_in_range;
    entry_t                  ram_rd_data;
    entry_t                  cur_entry;
    entry_t                  new_entry;
    logic                    new_active;
    logic                    ram_wr_en;
    logic [RUN_W-1:0]        trig_byte;
    logic [RUN_W-1:0]        clr_byte;
    logic [CNT_W-1:0]        count_now;
    logic [LVL_W-1:0]        top_now;
    logic [PER_W-1:0]        period_eff;
    div_req_t                div_req;
    div_rsp_t                div_rsp;
    logic [IDX_W-1:0]        shown_now;
    logic                    out_free;

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_beat       = s_tvalid && s_tready;
    assign idx_in_range = (int'(idx_reg) < ALARM_COUNT);
    assign out_free     = !m_tvalid_reg || m_tready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_reg <= TRIGGER_RESET;
            clear_reg   <= CLEAR_RESET;
            levels_reg  <= LEVELS_RESET;
            period_reg  <= PERIOD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_TRIGGER: trigger_reg <= cfg_wdata;
                REG_CLEAR:   clear_reg   <= cfg_wdata;
                REG_LEVELS:  levels_reg  <= cfg_wdata[15:0];
                REG_PERIOD:  period_reg  <= cfg_wdata[PER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // State memory: read on the accepted beat, write back in the update cycle
    assign ram_wr_en = (state_reg == ST_UPD) && (kind_reg == KIND_REPORT) && idx_in_range;

    dab_state_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (new_entry),
        .rd_en   (s_beat),
        .rd_addr (s_tdata[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // A never-written record reads as the reset value
    assign cur_entry = valid_reg[idx_reg] ? ram_rd_data : '0;
    assign trig_byte = trigger_reg[RUN_W*idx_reg +: RUN_W];
    assign clr_byte  = clear_reg[RUN_W*idx_reg +: RUN_W];

    dab_update u_update (
        .cur           (cur_entry),
        .cur_active    (active_reg[idx_reg]),
        .bad           (bad_reg),
        .tag           (tag_reg),
        .trigger_count (trig_byte),
        .clear_count   (clr_byte),
        .nxt           (new_entry),
        .nxt_active    (new_active)
    );

    // Count the on alarms and find the highest level
    always_comb begin
        count_now = '0;
        top_now   = '0;
        for (int i = 0; i < MAX_ALARMS; i++) begin
            if (active_reg[i]) begin
                count_now = count_now + 1'b1;
                if (levels_reg[LVL_W*i +: LVL_W] > top_now) begin
                    top_now = levels_reg[LVL_W*i +: LVL_W];
                end
            end
        end
    end

    assign period_eff     = (period_reg == '0) ? PER_W'(1) : period_reg;
    assign div_req.start  = (state_reg == ST_SUM) && (count_now != '0);
    assign div_req.count  = count_now;
    assign div_req.period = period_eff;

    dab_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .now     (time_reg),
        .rsp     (div_rsp)
    );

    // Select the pick-th on alarm from the lowest index
    always_comb begin
        logic [CNT_W-1:0] seen;
        logic             found;
        seen      = '0;
        found     = 1'b0;
        shown_now = '0;
        for (int i = 0; i < MAX_ALARMS; i++) begin
            if (mask_reg[i] && !found) begin
                if (seen == {1'b0, pick_reg}) begin
                    shown_now = IDX_W'(i);
                    found     = 1'b1;
                end
                seen = seen + 1'b1;
            end
        end
    end

    // Item sequencer and alarm flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            active_reg <= '0;
            valid_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_beat) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (kind_reg == KIND_CLEAR) begin
                        active_reg <= '0;
                        valid_reg  <= '0;
                    end else if (idx_in_range) begin
                        active_reg[idx_reg] <= new_active;
                        valid_reg[idx_reg]  <= 1'b1;
                    end
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    state_reg <= (count_now != '0) ? ST_DIV : ST_OUT;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Latch the item and the summary
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            kind_reg <= s_tuser[0];
            idx_reg  <= s_tdata[IDX_W-1:0];
            bad_reg  <= s_tdata[IDX_W];
            tag_reg  <= s_tdata[IDX_W+1 +: TAG_W];
            time_reg <= s_tdata[IDX_W+1+TAG_W +: TIME_W];
        end
        if (state_reg == ST_SUM) begin
            mask_reg  <= active_reg;
            count_reg <= count_now;
            top_reg   <= top_now;
            pick_reg  <= '0;
        end
        if (state_reg == ST_DIV && div_rsp.done) begin
            pick_reg <= div_rsp.pick;
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {6'b0, (count_reg != '0), shown_now, top_reg,
                            count_reg, mask_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sim/dab_checker.sv
// Scoreboard for the debounced alarm bank: watches the input, result and configuration
// ports, predicts every result beat and compares it field by field.
// Depends on dab_pkg.
module dab_checker import dab_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    // Result beat layout, lowest field in the lowest bits
    typedef struct packed {
        logic                  shown_valid;
        logic [IDX_W-1:0]      shown_alarm;
        logic [LVL_W-1:0]      top_level;
        logic [CNT_W-1:0]      on_count;
        logic [MAX_ALARMS-1:0] on_mask;
    } alarm_summary_t;

    localparam int SUMMARY_W = $bits(alarm_summary_t);

    // Shadow copy of the configuration registers
    logic [63:0]      trigger_bytes;
    logic [63:0]      clear_bytes;
    logic [15:0]      level_bits;
    logic [PER_W-1:0] period_ms;

    // Shadow copy of the per-alarm debounce state
    logic             alarm_on      [ALARM_COUNT];
    logic [RUN_W-1:0] bad_run       [ALARM_COUNT];
    logic [RUN_W-1:0] good_run      [ALARM_COUNT];
    logic [TAG_W-1:0] last_bad_tag  [ALARM_COUNT];
    logic [TAG_W-1:0] last_good_tag [ALARM_COUNT];

    alarm_summary_t expected_summaries[$];

    // Return every alarm to its idle state
    function automatic void clear_bank();
        for (int i = 0; i < ALARM_COUNT; i++) begin
            alarm_on[i]      = 1'b0;
            bad_run[i]       = '0;
            good_run[i]      = '0;
            last_bad_tag[i]  = '0;
            last_good_tag[i] = '0;
        end
    endfunction

    // Apply one item to the shadow bank and summarize the alarms that are on
    function automatic alarm_summary_t next_alarm_summary(
        input logic             kind,
        input logic [IDX_W-1:0] a,
        input logic             is_bad,
        input logic [TAG_W-1:0] tag,
        input logic [TIME_W-1:0] now
    );
        alarm_summary_t r;
        logic [63:0]    per;
        logic [63:0]    pick;
        logic [63:0]    seen;
        r = '0;
        if (kind == KIND_CLEAR) begin
            clear_bank();
        end else if (is_bad) begin
            // count a fresh bad tag, saturating, and drop the good run
            if (tag != last_bad_tag[a] && bad_run[a] != RUN_MAX)
                bad_run[a] = bad_run[a] + 1'b1;
            last_bad_tag[a] = tag;
            if (!alarm_on[a])
                alarm_on[a] = (bad_run[a] >= trigger_bytes[8*a +: 8]);
            good_run[a] = '0;
        end else begin
            // count a fresh good tag, saturating, and drop the bad run
            if (tag != last_good_tag[a] && good_run[a] != RUN_MAX)
                good_run[a] = good_run[a] + 1'b1;
            last_good_tag[a] = tag;
            if (alarm_on[a])
                alarm_on[a] = (good_run[a] < clear_bytes[8*a +: 8]);
            bad_run[a] = '0;
        end

        for (int i = 0; i < ALARM_COUNT; i++) begin
            if (alarm_on[i]) begin
                r.on_mask[i] = 1'b1;
                r.on_count   = r.on_count + 1'b1;
                if (level_bits[2*i +: LVL_W] > r.top_level)
                    r.top_level = level_bits[2*i +: LVL_W];
            end
        end

        // Rotate the display through the on alarms, a zero period acting as one
        if (r.on_count != 0) begin
            per  = (period_ms == 0) ? 64'd1 : 64'(period_ms);
            pick = (64'(now) % (64'(r.on_count) * per)) / per;
            seen = 0;
            for (int i = 0; i < ALARM_COUNT; i++) begin
                if (alarm_on[i]) begin
                    if (seen == pick) begin
                        r.shown_alarm = IDX_W'(i);
                        break;
                    end
                    seen++;
                end
            end
            r.shown_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Track config writes, check result beats, then queue the prediction for a new beat
    always @(posedge aclk) begin
        alarm_summary_t got;
        alarm_summary_t want;
        if (!aresetn) begin
            trigger_bytes = TRIGGER_RESET;
            clear_bytes   = CLEAR_RESET;
            level_bits    = LEVELS_RESET;
            period_ms     = PERIOD_RESET;
            clear_bank();
            expected_summaries.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TRIGGER: trigger_bytes = cfg_wdata;
                    REG_CLEAR:   clear_bytes   = cfg_wdata;
                    REG_LEVELS:  level_bits    = cfg_wdata[15:0];
                    REG_PERIOD:  period_ms     = cfg_wdata[PER_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got = m_tdata[SUMMARY_W-1:0];
                if (expected_summaries.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected: expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = expected_summaries.pop_front();
                    check_field("on_mask",     want.on_mask,     got.on_mask);
                    check_field("on_count",    want.on_count,    got.on_count);
                    check_field("top_level",   want.top_level,   got.top_level);
                    check_field("shown_alarm", want.shown_alarm, got.shown_alarm);
                    check_field("shown_valid", want.shown_valid, got.shown_valid);
                end
            end

            if (s_tvalid && s_tready)
                expected_summaries.push_back(next_alarm_summary(
                    s_tuser[0], s_tdata[2:0], s_tdata[3], s_tdata[35:4], s_tdata[67:36]));
        end
        pending = expected_summaries.size();
    end

endmodule

>>> sim/testbench.sv
// Top of the alarm bank simulation: clock, reset, stimulus, stalls and verdict.
// Instantiates debounced_alarm_bank and dab_checker; uses dab_pkg.
module testbench;
    import dab_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 200;
    localparam int SAT_REPORTS   = 265;
    localparam int PHASES        = 5;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    logic              steady;
    logic              hold_off_req;
    logic [TAG_W-1:0]  tag_next [ALARM_COUNT];
    logic [TIME_W-1:0] clock_ms;

    debounced_alarm_bank uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    dab_checker alarm_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort when no beat moves on either stream for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 30);
            end
        end
    end

    // Offer one beat, hold it until taken, then maybe idle before returning
    task automatic send_item(input logic kind, input logic [IDX_W-1:0] a, input logic is_bad,
                             input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, now, tag, is_bad, a};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (!steady && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    // Write all four registers back to back
    task automatic config_all(input logic [63:0] trig, input logic [63:0] clr,
                              input logic [15:0] lvl, input logic [15:0] per);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_TRIGGER;
        cfg_wdata <= trig;
        @(negedge aclk);
        cfg_addr  <= REG_CLEAR;
        cfg_wdata <= clr;
        @(negedge aclk);
        cfg_addr  <= REG_LEVELS;
        cfg_wdata <= 64'(lvl);
        @(negedge aclk);
        cfg_addr  <= REG_PERIOD;
        cfg_wdata <= 64'(per);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stop offering, wait for every expected beat, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [63:0] random_thresholds(input int unsigned limit);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
            r[8*i +: 8] = 8'($urandom_range(0, limit));
        return r;
    endfunction

    // Mostly same-polarity runs on one alarm with fresh tags; some repeats,
    // polarity flips, random tags, random times and clear-all beats
    task automatic random_traffic(input int n);
        int               sent;
        int               a;
        logic             pol;
        logic [TAG_W-1:0] tag;
        logic [TIME_W-1:0] now;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 4) begin
                send_item(KIND_CLEAR, IDX_W'($urandom), 1'($urandom), $urandom, $urandom);
                sent++;
            end else begin
                a   = $urandom_range(ALARM_COUNT - 1);
                pol = 1'($urandom_range(1));
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(99) < 15)
                        pol = ~pol;
                    case ($urandom_range(9))
                        0: tag = $urandom;
                        1: tag = tag_next[a];
                        default: begin
                            tag_next[a] = tag_next[a] + 1'b1;
                            tag = tag_next[a];
                        end
                    endcase
                    clock_ms = clock_ms + TIME_W'($urandom_range(0, 3000));
                    now = ($urandom_range(99) < 20) ? TIME_W'($urandom) : clock_ms;
                    send_item(KIND_REPORT, IDX_W'(a), pol, tag, now);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        steady       = 1'b0;
        hold_off_req = 1'b0;
        clock_ms     = '0;
        for (int i = 0; i < ALARM_COUNT; i++)
            tag_next[i] = $urandom;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset config: tag equal to the cleared tag, repeats, rotation edges
        send_item(KIND_REPORT, 3'd0, 1'b1, 32'h0,        32'h0);
        send_item(KIND_REPORT, 3'd0, 1'b1, 32'h1,        32'h0);
        send_item(KIND_REPORT, 3'd0, 1'b1, 32'h1,        32'd1999);
        send_item(KIND_REPORT, 3'd7, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_item(KIND_REPORT, 3'd3, 1'b1, 32'd5,        32'd2000);
        send_item(KIND_REPORT, 3'd0, 1'b0, 32'h0,        32'd4000);
        send_item(KIND_REPORT, 3'd0, 1'b0, 32'd9,        32'd5999);
        send_item(KIND_CLEAR,  3'd7, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_item(KIND_REPORT, 3'd2, 1'b0, 32'd3,        32'd6000);
        settle();

        // Zero trigger and clear counts, zero period
        config_all('0, '0, 16'hE41B, 16'd0);
        send_item(KIND_REPORT, 3'd1, 1'b1, 32'h0,        32'd12345);
        send_item(KIND_REPORT, 3'd6, 1'b1, 32'h0,        32'd1);
        send_item(KIND_REPORT, 3'd1, 1'b0, 32'h0,        32'd2);
        send_item(KIND_REPORT, 3'd2, 1'b1, 32'd77,       32'hFFFFFFFF);
        send_item(KIND_CLEAR,  3'd0, 1'b0, 32'h0,        32'h0);
        settle();

        // Drive one bad run past saturation with the largest trigger count
        config_all('1, '1, 16'hFFFF, 16'd1);
        for (int k = 1; k <= SAT_REPORTS; k++)
            send_item(KIND_REPORT, 3'd5, 1'b1, TAG_W'(k), TIME_W'(k));
        send_item(KIND_REPORT, 3'd5, 1'b0, 32'd1, 32'd300);
        send_item(KIND_REPORT, 3'd5, 1'b0, 32'd1, 32'd301);
        send_item(KIND_CLEAR,  3'd5, 1'b0, 32'd2, 32'd302);
        settle();

        // Random phases under varied settings
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: config_all(random_thresholds(4), random_thresholds(4),
                              16'($urandom), 16'($urandom_range(1, 50)));
                1: begin
                    config_all(random_thresholds(3), random_thresholds(3), 16'hFFFF, 16'hFFFF);
                    hold_off_req = 1'b1;
                end
                2: config_all(random_thresholds(8), random_thresholds(6),
                              16'($urandom), 16'd0);
                3: begin
                    config_all('0, '0, 16'h0000, 16'd1);
                    steady = 1'b1;
                end
                default: config_all({$urandom, $urandom}, {$urandom, $urandom},
                                    16'($urandom), 16'd2000);
            endcase
            random_traffic(PHASE_ITEMS);
            steady = 1'b0;
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
src/dab_pkg.sv
src/dab_state_ram.sv
src/dab_update.sv
src/dab_divider.sv
src/debounced_alarm_bank.sv
sim/dab_checker.sv
sim/testbench.sv
